/* src/s256h_pkg.sv */
// Package for the SHA-256 whole-block hasher: word types, initial hash values and round constants.
package s256h_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_CNT_W = 55;
   localparam int unsigned LEN_W       = 64;
   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned ROUND_IDX_W = $clog2(ROUNDS);
   localparam int unsigned POS_W       = $clog2(BLOCK_WORDS);
   localparam int unsigned OUT_IDX_W   = $clog2(HASH_WORDS);

   typedef logic [WORD_W-1:0]                   word_type;
   typedef logic [HASH_WORDS-1:0][WORD_W-1:0]  hash_type;
   typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] window_type;

   // The first padding word holds the 0x80 marker byte in its top byte.
   localparam word_type PAD_FIRST_WORD = 32'h8000_0000;

   // Entry 0 is H0 (the working variable a), entry 7 is H7 (h).
   localparam hash_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

/* src/s256h_if.sv */
// Valid/ready channel interfaces for message words in and digest words out.
interface s256h_req_if;
   import s256h_pkg::*;

   logic     valid;
   logic     ready;
   word_type message_word;
   logic     end_of_message;

   modport source (output valid, output message_word, output end_of_message, input ready);
   modport sink   (input valid, input message_word, input end_of_message, output ready);
endinterface

interface s256h_rsp_if;
   import s256h_pkg::*;

   logic     valid;
   logic     ready;
   word_type digest_word;
   logic     digest_last;

   modport source (output valid, output digest_word, output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

/* src/sha256_whole_block_hasher.sv */
// Top level of the SHA-256 whole-block hasher: word intake, round sequencer and digest output.
//
//  Channel | Port    | Direction | Beat payload
//  --------+---------+-----------+-------------------------------------------
//  request | req_bus | in        | message_word[31:0], end_of_message
//  result  | rsp_bus | out       | digest_word[31:0], digest_last
//
// A message word beat is taken while the block is idle. The sixteenth word of a
// block starts the rounds on the single shared round unit, then a fold of the
// result into the chain value, while req_bus.ready stays low. A block flagged
// last then runs the padding block the same way, after which the eight digest
// beats are offered; each waits as long as rsp_bus.ready stays low. Reset is
// synchronous and active high; it restores the initial hash values and clears
// the counters.
module sha256_whole_block_hasher (
   input logic    clock,
   input logic    reset,
   s256h_req_if.sink   req_bus,
   s256h_rsp_if.source rsp_bus
);
   import s256h_pkg::*;

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type               state_ff,      state_in;
   hash_type                chain_ff,      chain_in;
   hash_type                work_ff,       work_in;
   window_type              window_ff,     window_in;
   logic [POS_W-1:0]        pos_ff,        pos_in;
   logic [BLOCK_CNT_W-1:0]  blocks_ff,     blocks_in;
   logic [ROUND_IDX_W-1:0]  round_ff,      round_in;
   logic [OUT_IDX_W-1:0]    out_idx_ff,    out_idx_in;
   // The padding block is still owed for the current message.
   logic                    pad_due_ff,    pad_due_in;
   // The block now in flight is the padding block, so a digest follows.
   logic                    emit_due_ff,   emit_due_in;

   hash_type                rnd_work_next;
   word_type                rnd_sched_word;
   hash_type                folded;
   window_type              pad_window;
   logic [LEN_W-1:0]        length_bits;
   logic                    req_beat;
   logic                    rsp_beat;

   s256h_round u_round (
      .work       (work_ff),
      .window     (window_ff),
      .round_k    (ROUND_K[round_ff]),
      .work_next  (rnd_work_next),
      .sched_word (rnd_sched_word)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_EMIT);
   assign rsp_bus.digest_word = chain_ff[0];
   assign rsp_bus.digest_last = (out_idx_ff == OUT_IDX_W'(HASH_WORDS - 1));

   assign req_beat = req_bus.valid && req_bus.ready;
   assign rsp_beat = rsp_bus.valid && rsp_bus.ready;

   // The message length in bits is the block count times 512.
   assign length_bits = {blocks_ff, 9'b0};

   always_comb begin
      pad_window     = '0;
      pad_window[0]  = PAD_FIRST_WORD;
      pad_window[14] = length_bits[LEN_W-1:WORD_W];
      pad_window[15] = length_bits[WORD_W-1:0];
      for (int i = 0; i < HASH_WORDS; i++) begin
         folded[i] = chain_ff[i] + work_ff[i];
      end
   end

   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      window_in   = window_ff;
      pos_in      = pos_ff;
      blocks_in   = blocks_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      pad_due_in  = pad_due_ff;
      emit_due_in = emit_due_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               // New words enter at the top of the window; the oldest sits at entry 0.
               window_in = {req_bus.message_word, window_ff[BLOCK_WORDS-1:1]};
               pos_in    = pos_ff + 1'b1;
               if (pos_ff == POS_W'(BLOCK_WORDS - 1)) begin
                  blocks_in  = blocks_ff + 1'b1;
                  pad_due_in = req_bus.end_of_message;
                  work_in    = chain_ff;
                  round_in   = '0;
                  state_in   = ST_ROUND;
               end
            end
         end

         ST_ROUND: begin
            work_in   = rnd_work_next;
            window_in = {rnd_sched_word, window_ff[BLOCK_WORDS-1:1]};
            round_in  = round_ff + 1'b1;
            if (round_ff == ROUND_IDX_W'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end

         ST_FOLD: begin
            chain_in = folded;
            if (pad_due_ff) begin
               // Last data block is done: run the padding block straight away.
               pad_due_in  = 1'b0;
               emit_due_in = 1'b1;
               window_in   = pad_window;
               work_in     = folded;
               round_in    = '0;
               state_in    = ST_ROUND;
            end else if (emit_due_ff) begin
               out_idx_in = '0;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (rsp_beat) begin
               // Rotate so the next digest word sits at entry 0.
               chain_in   = {chain_ff[0], chain_ff[HASH_WORDS-1:1]};
               out_idx_in = out_idx_ff + 1'b1;
               if (out_idx_ff == OUT_IDX_W'(HASH_WORDS - 1)) begin
                  chain_in    = HASH_INIT;
                  blocks_in   = '0;
                  emit_due_in = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= HASH_INIT;
         pos_ff      <= '0;
         blocks_ff   <= '0;
         round_ff    <= '0;
         out_idx_ff  <= '0;
         pad_due_ff  <= 1'b0;
         emit_due_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         pos_ff      <= pos_in;
         blocks_ff   <= blocks_in;
         round_ff    <= round_in;
         out_idx_ff  <= out_idx_in;
         pad_due_ff  <= pad_due_in;
         emit_due_ff <= emit_due_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      window_ff <= window_in;
   end

   // Intake and digest output never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("intake and digest output active together");

   // The word that completes a block starts round zero on the next cycle.
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (req_beat && pos_ff == POS_W'(BLOCK_WORDS - 1))
         |=> (state_ff == ST_ROUND && round_ff == '0))
      else $error("completed block did not start the rounds");

   // The last round is always followed by the fold cycle.
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == ROUND_IDX_W'(ROUNDS - 1)) |=> (state_ff == ST_FOLD))
      else $error("rounds did not end in the fold cycle");

   // Digest output only follows the padding block.
   a_emit_after_pad: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD && !pad_due_ff && emit_due_ff) |=> (state_ff == ST_EMIT))
      else $error("padding block not followed by digest output");

   // After the final digest beat the hasher is back at its initial state.
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_bus.digest_last)
         |=> (chain_ff == HASH_INIT && blocks_ff == '0 && pos_ff == '0))
      else $error("hasher not re-initialized after the digest");

endmodule

/* src/s256h_round.sv */
// One SHA-256 compression round plus one message schedule expansion step.
module s256h_round (
   input  s256h_pkg::hash_type   work,
   input  s256h_pkg::window_type window,
   input  s256h_pkg::word_type   round_k,
   output s256h_pkg::hash_type   work_next,
   output s256h_pkg::word_type   sched_word
);
   import s256h_pkg::*;

   function automatic word_type ror(input word_type v, input int unsigned s);
      return word_type'((v >> s) | (v << (WORD_W - s)));
   endfunction

   word_type big_sigma0;
   word_type big_sigma1;
   word_type choose;
   word_type majority;
   word_type temp1;
   word_type temp2;
   word_type small_sigma0;
   word_type small_sigma1;

   // The window holds W[t] .. W[t+15]; W[t] is consumed by this round.
   always_comb begin
      big_sigma1 = ror(work[4], 6) ^ ror(work[4], 11) ^ ror(work[4], 25);
      big_sigma0 = ror(work[0], 2) ^ ror(work[0], 13) ^ ror(work[0], 22);
      choose     = (work[4] & work[5]) ^ (~work[4] & work[6]);
      majority   = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
      temp1      = work[7] + big_sigma1 + choose + round_k + window[0];
      temp2      = big_sigma0 + majority;

      work_next    = {work[6:4], work[3] + temp1, work[2:0], temp1 + temp2};

      small_sigma0 = ror(window[1], 7) ^ ror(window[1], 18) ^ (window[1] >> 3);
      small_sigma1 = ror(window[14], 17) ^ ror(window[14], 19) ^ (window[14] >> 10);
      sched_word   = small_sigma1 + window[9] + small_sigma0 + window[0];
   end

endmodule

/* tb/sha256_whole_block_hasher_test.sv */
// Self-checking testbench for the SHA-256 whole-block hasher, with its own digest predictor.
module sha256_whole_block_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;

   import s256h_pkg::*;

   // The run is cut off at this many clock cycles. The slowest correct run is far shorter.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // These are the cycles to wait after the last digest beat. They cover a data block and a
   // padding block, so they outlast any beat that the block might still send.
   localparam int unsigned DRAIN_CYCLES = 200;
   // This is how long the receiver refuses digest beats during the one long hold-off.
   localparam int unsigned HOLD_CYCLES = 600;
   // This is the minimum number of random message words after the directed table.
   localparam int unsigned RANDOM_WORDS = 305;

   // These are the initial hash values and round constants of FIPS 180-4. They are kept
   // here so that a wrong constant in the design cannot hide behind a shared copy.
   localparam word_type SHA_IV [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type SHA_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // This is the well-known SHA-256 digest of 64 zero bytes. It is the digest of the first
   // directed message, because an end flag in mid-block does not change the message.
   localparam word_type ZERO_BLOCK_DIGEST [HASH_WORDS] = '{
      32'hf5a5fd42, 32'hd16a2030, 32'h2798ef6e, 32'hd309979b,
      32'h43003d23, 32'h20d9f0e8, 32'hea9831a9, 32'h2759fb4b
   };

   typedef struct packed {
      word_type word;
      logic     eom;
      logic     zero_digest;   // The digest of this message is typed in as ZERO_BLOCK_DIGEST.
   } stim_row_type;

   typedef struct {
      word_type word;
      logic     last;
   } digest_beat_type;

   // This is the directed table. The first sixteen rows are one all-zero block. An end flag
   // stands in mid-block at row 7, where it is ignored, and on the block boundary at row 15,
   // where the message ends. The remaining rows push extreme words into the next block,
   // including another ignored end flag, and the random part then carries that block on.
   localparam int unsigned DIRECTED_ROWS = 25;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}, '{32'h0000_0000, 1'b1, 1'b1},
      '{32'hffff_ffff, 1'b0, 1'b0}, '{32'h0000_0001, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0}, '{32'haaaa_aaaa, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0}, '{32'hffff_ffff, 1'b1, 1'b0},
      '{32'h7fff_ffff, 1'b0, 1'b0}, '{32'hffff_fffe, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   s256h_req_if req_bus ();
   s256h_rsp_if rsp_bus ();

   sha256_whole_block_hasher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // The digest predictor keeps its own chaining value, its own block window, its own word
   // position and its own block count.
   word_type               chain_model [HASH_WORDS];
   word_type               window_model [BLOCK_WORDS];
   logic [POS_W-1:0]       pos_model;
   logic [BLOCK_CNT_W-1:0] blocks_model;

   // These are the digest beats that the design still owes, oldest first.
   digest_beat_type pending_digest [$];

   int unsigned failures       = 0;
   int unsigned words_sent     = 0;
   int unsigned messages_sent  = 0;
   int unsigned beats_checked  = 0;
   int unsigned mid_flags_sent = 0;
   int unsigned cycle_count    = 0;
   bit          hold_off       = 1'b0;
   bit          steady_stretch = 1'b0;

   function automatic word_type rotr(input word_type v, input int unsigned s);
      return (v >> s) | (v << (WORD_W - s));
   endfunction

   // This function runs the 64 rounds over one block and folds the result into the chain.
   // The message schedule is computed in place over a 16-word window.
   function automatic void compress_block(input word_type blk [BLOCK_WORDS]);
      word_type w [BLOCK_WORDS];
      word_type r [HASH_WORDS];
      word_type lo, hi, t1, t2;
      int unsigned j;
      w = blk;
      r = chain_model;
      for (int i = 0; i < ROUNDS; i++) begin
         j = i & 15;
         if (i >= 16) begin
            lo = w[(i - 15) & 15];
            hi = w[(i - 2) & 15];
            w[j] = w[j] + (rotr(lo, 7) ^ rotr(lo, 18) ^ (lo >> 3)) + w[(i - 7) & 15]
                   + (rotr(hi, 17) ^ rotr(hi, 19) ^ (hi >> 10));
         end
         t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
              + ((r[4] & r[5]) ^ (~r[4] & r[6])) + SHA_K[i] + w[j];
         t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
              + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6];
         r[6] = r[5];
         r[5] = r[4];
         r[4] = r[3] + t1;
         r[3] = r[2];
         r[2] = r[1];
         r[1] = r[0];
         r[0] = t1 + t2;
      end
      for (int k = 0; k < HASH_WORDS; k++) begin
         chain_model[k] = chain_model[k] + r[k];
      end
   endfunction

   // This function takes one accepted message word. It returns 1 when the word finishes a
   // message, and the digest then comes back through the output argument.
   function automatic bit absorb_word(input word_type word, input logic eom,
                                      output word_type digest [HASH_WORDS]);
      word_type    pad [BLOCK_WORDS];
      logic [63:0] length_bits;
      window_model[pos_model] = word;
      pos_model = pos_model + 1'b1;
      if (pos_model != 0) begin
         return 1'b0;
      end
      compress_block(window_model);
      blocks_model = blocks_model + 1'b1;
      if (!eom) begin
         return 1'b0;
      end
      // The padding block holds the marker bit, zeros, and the message length in bits.
      length_bits = {blocks_model, 9'b0};
      foreach (pad[k]) pad[k] = '0;
      pad[0]  = 32'h8000_0000;
      pad[14] = length_bits[63:32];
      pad[15] = length_bits[31:0];
      compress_block(pad);
      digest = chain_model;
      chain_model = SHA_IV;
      blocks_model = '0;
      return 1'b1;
   endfunction

   // Most gaps are zero or short and a few are long. During a steady stretch there are none.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (steady_stretch || roll < 45) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 10);
   endfunction

   // The random words are weighted toward the all-zero and all-one extremes and toward
   // single set bits. Plain random words make up the rest.
   function automatic word_type pick_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         return '0;
      end
      if (roll < 20) begin
         return '1;
      end
      if (roll < 27) begin
         return word_type'(1) << $urandom_range(WORD_W - 1);
      end
      return $urandom;
   endfunction

   // This task offers one message word. The call starts and ends at a falling edge, and each
   // falling edge sees at most one assignment to valid. The prediction is made at the edge
   // that accepts the beat.
   task automatic send_word(input word_type word, input logic eom, input logic zero_digest);
      int unsigned     gap;
      word_type        digest [HASH_WORDS];
      digest_beat_type beat;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.message_word   <= word;
      req_bus.end_of_message <= eom;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      words_sent++;
      if (absorb_word(word, eom, digest)) begin
         if (zero_digest) begin
            digest = ZERO_BLOCK_DIGEST;
         end
         for (int k = 0; k < HASH_WORDS; k++) begin
            beat.word = digest[k];
            beat.last = (k == HASH_WORDS - 1);
            pending_digest.push_back(beat);
         end
         messages_sent++;
      end else if (eom) begin
         mid_flags_sent++;
      end
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   // This process sends the stimulus, waits for the last digest, and reports the verdict.
   initial begin : message_sender
      int unsigned gen_pos;
      int unsigned rand_count;
      bit          closed;
      logic        eom;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.message_word   = '0;
      req_bus.end_of_message = 1'b0;
      chain_model  = SHA_IV;
      foreach (window_model[k]) window_model[k] = '0;
      pos_model    = '0;
      blocks_model = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[r]) begin
         send_word(DIRECTED[r].word, DIRECTED[r].eom, DIRECTED[r].zero_digest);
      end

      // The random part carries on from the directed table, which left nine words in an open block.
      // gen_pos follows the word position so that an end flag can land on a boundary on
      // purpose. Every flag on a boundary closes the message, and stray flags in mid-block
      // serve as noise. Once the word budget is spent, the open message is closed.
      gen_pos    = DIRECTED_ROWS % BLOCK_WORDS;
      rand_count = 0;
      closed     = 1'b0;
      while (rand_count < RANDOM_WORDS || !closed) begin
         if (gen_pos == BLOCK_WORDS - 1) begin
            eom = (rand_count >= RANDOM_WORDS) || ($urandom_range(99) < 55);
         end else begin
            eom = ($urandom_range(7) == 0);
         end
         closed = (gen_pos == BLOCK_WORDS - 1) && eom;
         send_word(pick_word(), eom, 1'b0);
         gen_pos = (gen_pos + 1) % BLOCK_WORDS;
         rand_count++;
      end
      req_bus.valid <= 1'b0;

      while (pending_digest.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d message words (%0d ignored end flags), closing %0d messages.",
               words_sent, mid_flags_sent, messages_sent);
      $display("Checked %0d digest beats under random idling on both channels.",
               beats_checked);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // The receiver alternates runs of readiness with stalls. During the long hold-off it
   // stays low throughout.
   initial begin : digest_receiver
      int unsigned run_len;
      int unsigned stall_len;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         run_len = $urandom_range(20, 1);
         repeat (run_len) begin
            @(negedge clock);
            rsp_bus.ready <= !hold_off;
         end
         stall_len = pick_gap();
         repeat (stall_len) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   // The long hold-off starts once the second message is in. Its digest then has nowhere to
   // go. The sender keeps offering words, so the block fills up and stops taking input.
   initial begin : long_hold
      wait (messages_sent >= 2);
      hold_off = 1'b1;
      for (int c = 0; c < HOLD_CYCLES; c++) begin
         @(posedge clock);
      end
      hold_off = 1'b0;
   end

   // This process turns steady stretches with no idling on and off now and then.
   initial begin : idle_pattern
      forever begin
         repeat (150) @(posedge clock);
         steady_stretch = ($urandom_range(3) == 0);
      end
   end

   // Each digest beat is compared field by field with the oldest expected beat.
   always @(posedge clock) begin
      digest_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_digest.size() == 0) begin
            $display("%0t: unexpected digest beat: expected none, got %h last %b",
                     $realtime, rsp_bus.digest_word, rsp_bus.digest_last);
            failures++;
         end else begin
            want = pending_digest.pop_front();
            beats_checked++;
            if (rsp_bus.digest_word !== want.word) begin
               $display("%0t: digest_word mismatch: expected %h, got %h",
                        $realtime, want.word, rsp_bus.digest_word);
               failures++;
            end
            if (rsp_bus.digest_last !== want.last) begin
               $display("%0t: digest_last mismatch: expected %b, got %b",
                        $realtime, want.last, rsp_bus.digest_last);
               failures++;
            end
         end
      end
   end

   // The watchdog ends a hung run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d digest beats still expected",
               $realtime, cycle_count, pending_digest.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
